[rtl/abkf_pkg.sv]
// Shared types, constants and saturation helpers for the angle/bias Kalman filter.
package abkf_pkg;

  localparam int ANG_W  = 32;  // angle / rate / bias width
  localparam int COV_W  = 56;  // covariance entry width
  localparam int NV_W   = 48;  // noise variance register width
  localparam int DT_W   = 32;  // time step width, all fraction
  localparam int CIDX_W = 3;   // config register index width
  localparam int WIDE_W = 66;  // headroom for sums before saturation

  localparam logic [NV_W-1:0] ANGLE_NOISE_RST = 48'd10995116;
  localparam logic [NV_W-1:0] BIAS_NOISE_RST  = 48'd1099511628;
  localparam logic [NV_W-1:0] MEAS_NOISE_RST  = 48'd549755813888;

  typedef enum logic [CIDX_W-1:0] {
    REG_ANGLE_NOISE = 3'd0,
    REG_BIAS_NOISE  = 3'd1,
    REG_MEAS_NOISE  = 3'd2,
    REG_START_ANGLE = 3'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_GO,
    S_MUL_WAIT,
    S_DIV_SET,
    S_DIV_RUN,
    S_DONE
  } state_t;

  // Multiply steps in order of execution
  typedef enum logic [3:0] {
    SP_ANG,
    SP_P11DT,
    SP_INNER,
    SP_QB,
    SP_K0Y,
    SP_K1Y,
    SP_K1P00,
    SP_K1P01,
    SP_K0P00,
    SP_K0P01
  } step_t;

  function automatic logic signed [COV_W-1:0] sat_cov(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = (WIDE_W'(1) <<< (COV_W-1)) - WIDE_W'(1);
    lo = -hi - WIDE_W'(1);
    if (v > hi) sat_cov = hi[COV_W-1:0];
    else if (v < lo) sat_cov = lo[COV_W-1:0];
    else sat_cov = v[COV_W-1:0];
  endfunction

  function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = (WIDE_W'(1) <<< (ANG_W-1)) - WIDE_W'(1);
    lo = -hi - WIDE_W'(1);
    if (v > hi) sat_ang = hi[ANG_W-1:0];
    else if (v < lo) sat_ang = lo[ANG_W-1:0];
    else sat_ang = v[ANG_W-1:0];
  endfunction

endpackage

[rtl/abkf_if.sv]
// Valid/ready channel interfaces for filter input and result beats.
interface abkf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] meas_angle;
  logic [31:0] gyro_rate;
  logic [31:0] step_time;
  modport source (output valid, meas_angle, gyro_rate, step_time, input ready);
  modport sink   (input valid, meas_angle, gyro_rate, step_time, output ready);
endinterface

interface abkf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] angle_estimate;
  logic [31:0] bias_estimate;
  modport source (output valid, angle_estimate, bias_estimate, input ready);
  modport sink   (input valid, angle_estimate, bias_estimate, output ready);
endinterface

[rtl/abkf_mul.sv]
// Shared signed multiplier: four 32x32 partial products, accumulated, then shift and clamp.
module abkf_mul #(
  parameter int COV_FRAC_BITS = 40
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] op_a,
  input  logic signed [63:0] op_b,
  input  logic               cov_shift,
  output logic               done,
  output logic signed [63:0] res
);

  logic [63:0]  am, bm;
  logic         neg, sel_cov, busy, fin, pp_vld;
  logic [2:0]   cnt;
  logic [63:0]  pp;
  logic [1:0]   pp_pos;
  logic [127:0] acc;
  logic [31:0]  a_half, b_half;
  logic [127:0] shifted;
  logic [63:0]  clipped;
  logic [127:0] lim;

  // operand halves picked by the partial product counter
  assign a_half = cnt[1] ? am[63:32] : am[31:0];
  assign b_half = cnt[0] ? bm[63:32] : bm[31:0];

  // final shift and magnitude clamp at 2^62
  always_comb begin
    lim = 128'd1 << 62;
    shifted = sel_cov ? (acc >> COV_FRAC_BITS) : (acc >> 32);
    clipped = (shifted > lim) ? lim[63:0] : shifted[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin <= 1'b0;
      pp_vld <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        am <= op_a[63] ? 64'(-op_a) : 64'(op_a);
        bm <= op_b[63] ? 64'(-op_b) : 64'(op_b);
        neg <= op_a[63] ^ op_b[63];
        sel_cov <= cov_shift;
        cnt <= '0;
        busy <= 1'b1;
        acc <= '0;
        pp_vld <= 1'b0;
      end else begin
        if (busy) begin
          if (cnt == 3'd4) begin
            busy <= 1'b0;
            fin <= 1'b1;
            pp_vld <= 1'b0;
          end else begin
            pp <= a_half * b_half;
            pp_pos <= 2'(cnt[1]) + 2'(cnt[0]);
            pp_vld <= 1'b1;
            cnt <= cnt + 3'd1;
          end
        end
        if (pp_vld) begin
          acc <= acc + ({64'd0, pp} << {pp_pos, 5'd0});
        end
        if (fin) begin
          fin <= 1'b0;
          res <= neg ? -$signed(clipped) : $signed(clipped);
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/angle_bias_kalman_filter.sv]
// Two-state angle/gyro-bias Kalman filter built around one shared multiplier.
//
// Input channel in_ch carries meas_angle, gyro_rate (signed Q16.16) and
// step_time (unsigned Q0.32). Result channel out_ch carries angle_estimate and
// bias_estimate (signed Q16.16), one result beat per input beat.
// The config port writes noise variances (index 0..2) and start_angle (3);
// writing start_angle loads the angle and clears bias and covariance.
// An item runs ten multiplies on the shared 32x32 unit plus two restoring
// divisions of 56+COV_FRAC_BITS steps each, one quotient bit a cycle, after
// which a final step latches the gain. When the innovation variance is not
// positive the divisions are skipped.
// in_ch.ready is high only while idle; one item is in work at a time.
// The result sits in an output register; a new item can be taken while it
// waits, and the next result waits for that register to drain.
// Reset restores the default noise values and zeros angle, bias and
// covariance.
module angle_bias_kalman_filter
  import abkf_pkg::*;
#(
  parameter int COV_FRAC_BITS = 40
) (
  input  logic                clk,
  input  logic                rst,
  abkf_in_if.sink             in_ch,
  abkf_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [NV_W-1:0]     cfg_data
);

  localparam int NW  = COV_W + COV_FRAC_BITS;
  localparam int DCW = $clog2(NW + 1);

  state_t state, state_next;
  step_t  step;

  logic [NV_W-1:0] q_angle, q_bias, r_meas;
  logic signed [ANG_W-1:0] ang, bias;
  logic signed [COV_W-1:0] p00, p01, p10, p11;
  logic [DT_W-1:0] dt;
  logic signed [ANG_W-1:0] meas;
  logic signed [ANG_W:0] rate, y;
  logic signed [63:0] inner;
  logic signed [COV_W-1:0] k0, k1;

  // divider state
  logic [NW-1:0] num;
  logic [COV_W:0] rem;
  logic [COV_W:0] dvs;
  logic [COV_W-1:0] quo;
  logic q_ovf, div_neg, div_second;
  logic [DCW-1:0] div_cnt;
  logic [COV_W+1:0] rem2;
  logic rem_ge;
  logic signed [COV_W+1:0] s_sum;
  logic [COV_W:0] p00_mag, p10_mag;
  logic [COV_W-1:0] k_mag;
  logic signed [COV_W-1:0] k_val;

  // multiplier hookup
  logic mul_start, mul_done, mul_cov;
  logic signed [63:0] mul_a, mul_b, mul_res;
  logic signed [WIDE_W-1:0] rw;

  logic out_free;
  logic div_last;

  abkf_mul #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
    .cov_shift(mul_cov), .done(mul_done), .res(mul_res)
  );

  assign rw = WIDE_W'(mul_res);
  assign out_free = !out_ch.valid || out_ch.ready;
  // all quotient bits shifted in; this cycle latches the gain and sets up the next division
  assign div_last = (div_cnt == DCW'(NW));

  // operand select per step
  always_comb begin
    mul_a = 64'(signed'({1'b0, dt}));
    mul_b = '0;
    mul_cov = 1'b0;
    unique case (step)
      SP_ANG:   mul_b = 64'(rate);
      SP_P11DT: mul_b = 64'(p11);
      SP_INNER: mul_b = inner;
      SP_QB:    mul_b = 64'(signed'({1'b0, q_bias}));
      SP_K0Y:   begin mul_a = 64'(k0); mul_b = 64'(y);   mul_cov = 1'b1; end
      SP_K1Y:   begin mul_a = 64'(k1); mul_b = 64'(y);   mul_cov = 1'b1; end
      SP_K1P00: begin mul_a = 64'(k1); mul_b = 64'(p00); mul_cov = 1'b1; end
      SP_K1P01: begin mul_a = 64'(k1); mul_b = 64'(p01); mul_cov = 1'b1; end
      SP_K0P00: begin mul_a = 64'(k0); mul_b = 64'(p00); mul_cov = 1'b1; end
      SP_K0P01: begin mul_a = 64'(k0); mul_b = 64'(p01); mul_cov = 1'b1; end
      default:  mul_b = '0;
    endcase
  end

  // divider datapath
  always_comb begin
    s_sum = (COV_W+2)'(p00) + (COV_W+2)'(signed'({1'b0, r_meas}));
    p00_mag = p00[COV_W-1] ? (COV_W+1)'(-(COV_W+1)'(p00)) : (COV_W+1)'(p00);
    p10_mag = p10[COV_W-1] ? (COV_W+1)'(-(COV_W+1)'(p10)) : (COV_W+1)'(p10);
    rem2 = {rem, num[NW-1]};
    rem_ge = rem2 >= {1'b0, dvs};
    k_mag = (q_ovf || quo[COV_W-1]) ? {1'b0, {(COV_W-1){1'b1}}} : quo;
    k_val = div_neg ? -$signed(k_mag) : $signed(k_mag);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_ch.valid) state_next = S_MUL_GO;
      S_MUL_GO:   state_next = S_MUL_WAIT;
      S_MUL_WAIT: if (mul_done) begin
        if (step == SP_QB) state_next = S_DIV_SET;
        else if (step == SP_K0P01) state_next = S_DONE;
        else state_next = S_MUL_GO;
      end
      S_DIV_SET:  state_next = (s_sum > 0) ? S_DIV_RUN : S_MUL_GO;
      S_DIV_RUN:  if (div_last && div_second) state_next = S_MUL_GO;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = (state == S_IDLE);
    mul_start = (state == S_MUL_GO);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // filter state, config and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      q_angle <= ANGLE_NOISE_RST;
      q_bias <= BIAS_NOISE_RST;
      r_meas <= MEAS_NOISE_RST;
      ang <= '0;
      bias <= '0;
      p00 <= '0;
      p01 <= '0;
      p10 <= '0;
      p11 <= '0;
      step <= SP_ANG;
      out_ch.valid <= 1'b0;
    end else begin
      // result register handshake
      if (state == S_DONE && out_free) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ANGLE_NOISE: q_angle <= cfg_data;
          REG_BIAS_NOISE:  q_bias <= cfg_data;
          REG_MEAS_NOISE:  r_meas <= cfg_data;
          REG_START_ANGLE: begin
            ang <= cfg_data[ANG_W-1:0];
            bias <= '0;
            p00 <= '0;
            p01 <= '0;
            p10 <= '0;
            p11 <= '0;
          end
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          meas <= in_ch.meas_angle;
          dt <= in_ch.step_time;
          rate <= (ANG_W+1)'(signed'(in_ch.gyro_rate)) - (ANG_W+1)'(bias);
          step <= SP_ANG;
        end
        S_MUL_WAIT: if (mul_done) begin
          if (step != SP_K0P01) step <= step_t'(step + 4'd1);
          unique case (step)
            SP_ANG:   ang <= sat_ang(WIDE_W'(ang) + rw);
            SP_P11DT: begin
              inner <= 64'(rw - WIDE_W'(p01) - WIDE_W'(p10)
                           + WIDE_W'(signed'({1'b0, q_angle})));
              p01 <= sat_cov(WIDE_W'(p01) - rw);
              p10 <= sat_cov(WIDE_W'(p10) - rw);
            end
            SP_INNER: p00 <= sat_cov(WIDE_W'(p00) + rw);
            SP_QB:    p11 <= sat_cov(WIDE_W'(p11) + rw);
            SP_K0Y:   ang <= sat_ang(WIDE_W'(ang) + rw);
            SP_K1Y:   bias <= sat_ang(WIDE_W'(bias) + rw);
            SP_K1P00: p10 <= sat_cov(WIDE_W'(p10) - rw);
            SP_K1P01: p11 <= sat_cov(WIDE_W'(p11) - rw);
            SP_K0P00: p00 <= sat_cov(WIDE_W'(p00) - rw);
            SP_K0P01: p01 <= sat_cov(WIDE_W'(p01) - rw);
            default: ;
          endcase
        end
        S_DIV_SET: begin
          y <= (ANG_W+1)'(meas) - (ANG_W+1)'(ang);
          k0 <= '0;
          k1 <= '0;
          dvs <= s_sum[COV_W:0];
          num <= NW'(p00_mag[COV_W-1:0]) << COV_FRAC_BITS;
          div_neg <= p00[COV_W-1];
          div_second <= 1'b0;
          rem <= '0;
          quo <= '0;
          q_ovf <= 1'b0;
          div_cnt <= '0;
        end
        S_DIV_RUN: begin
          if (div_last) begin
            // finished one quotient; latch gain and set up the next
            if (!div_second) k0 <= k_val;
            else k1 <= k_val;
            num <= NW'(p10_mag[COV_W-1:0]) << COV_FRAC_BITS;
            div_neg <= p10[COV_W-1];
            div_second <= 1'b1;
            rem <= '0;
            quo <= '0;
            q_ovf <= 1'b0;
            div_cnt <= '0;
          end else begin
            div_cnt <= div_cnt + DCW'(1);
          end
          if (!div_last) begin
            num <= num << 1;
            rem <= rem_ge ? (COV_W+1)'(rem2 - {1'b0, dvs}) : rem2[COV_W:0];
            quo <= {quo[COV_W-2:0], rem_ge};
            q_ovf <= q_ovf | quo[COV_W-1];
          end
        end
        S_DONE: if (out_free) begin
          out_ch.angle_estimate <= ang;
          out_ch.bias_estimate <= bias;
        end
        default: ;
      endcase
    end
  end

endmodule

[sim/abkf_checker.sv]
// Result checker for the angle/bias Kalman filter: tracks filter state, predicts and compares beats.
module abkf_checker
  import abkf_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  abkf_in_if              in_ch,
  abkf_out_if             out_ch,
  input  logic            cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [NV_W-1:0] cfg_data,
  output int              errors,
  output int              pending
);

  localparam longint COV_HI = (64'sd1 <<< 55) - 1;
  localparam longint COV_LO = -COV_HI - 1;
  localparam longint ANG_HI = 64'sd2147483647;
  localparam longint ANG_LO = -64'sd2147483648;
  localparam longint MAG_CAP = 64'sd1 <<< 62;
  localparam int DT_SHIFT = 32;
  localparam int GAIN_SHIFT = 40;

  typedef struct packed {
    logic [ANG_W-1:0] angle;
    logic [ANG_W-1:0] bias;
  } estimate_t;

  // filter copy
  longint q_angle, q_bias, r_meas;
  longint angle, bias;
  longint p00, p01, p10, p11;
  estimate_t estimate_q[$];

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // exact product of magnitudes, shifted and capped, sign restored
  function automatic longint mul_shr(longint a, longint b, int sh);
    logic [127:0] prod;
    logic [127:0] r;
    logic [63:0] ma, mb;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    prod = {64'd0, ma} * {64'd0, mb};
    r = prod >> sh;
    if (r > MAG_CAP) r = MAG_CAP;
    return ((a < 0) != (b < 0)) ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  function automatic longint gain(longint n, longint d);
    logic [127:0] num;
    logic [127:0] q;
    num = {64'd0, 64'(n < 0 ? -n : n)} << GAIN_SHIFT;
    q = num / {64'd0, 64'(d)};
    if (q > COV_HI) q = COV_HI;
    return n < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  task automatic reload(longint a);
    angle = a;
    bias = 0;
    p00 = 0; p01 = 0; p10 = 0; p11 = 0;
  endtask

  task automatic filter_step(logic [31:0] meas_raw, logic [31:0] rate_raw,
                             logic [31:0] dt_raw);
    longint meas, rate, dt, inner, s, k0, k1, y, n00, n01, n10, n11;
    estimate_t e;
    meas = longint'($signed(meas_raw));
    rate = longint'($signed(rate_raw)) - bias;
    dt = longint'({32'd0, dt_raw});
    k0 = 0;
    k1 = 0;
    // predict
    angle = clip(angle + mul_shr(dt, rate, DT_SHIFT), ANG_LO, ANG_HI);
    inner = mul_shr(dt, p11, DT_SHIFT) - p01 - p10 + q_angle;
    n00 = clip(p00 + mul_shr(dt, inner, DT_SHIFT), COV_LO, COV_HI);
    n01 = clip(p01 - mul_shr(dt, p11, DT_SHIFT), COV_LO, COV_HI);
    n10 = clip(p10 - mul_shr(dt, p11, DT_SHIFT), COV_LO, COV_HI);
    n11 = clip(p11 + mul_shr(dt, q_bias, DT_SHIFT), COV_LO, COV_HI);
    // update; no gain when the innovation variance is not positive
    s = n00 + r_meas;
    if (s > 0) begin
      k0 = gain(n00, s);
      k1 = gain(n10, s);
    end
    y = meas - angle;
    angle = clip(angle + mul_shr(k0, y, GAIN_SHIFT), ANG_LO, ANG_HI);
    bias = clip(bias + mul_shr(k1, y, GAIN_SHIFT), ANG_LO, ANG_HI);
    p00 = clip(n00 - mul_shr(k0, n00, GAIN_SHIFT), COV_LO, COV_HI);
    p01 = clip(n01 - mul_shr(k0, n01, GAIN_SHIFT), COV_LO, COV_HI);
    p10 = clip(n10 - mul_shr(k1, n00, GAIN_SHIFT), COV_LO, COV_HI);
    p11 = clip(n11 - mul_shr(k1, n01, GAIN_SHIFT), COV_LO, COV_HI);
    e.angle = angle[31:0];
    e.bias = bias[31:0];
    estimate_q.push_back(e);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      q_angle = ANGLE_NOISE_RST;
      q_bias = BIAS_NOISE_RST;
      r_meas = MEAS_NOISE_RST;
      reload(0);
      estimate_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_ANGLE_NOISE: q_angle = longint'({16'd0, cfg_data});
          REG_BIAS_NOISE:  q_bias = longint'({16'd0, cfg_data});
          REG_MEAS_NOISE:  r_meas = longint'({16'd0, cfg_data});
          REG_START_ANGLE: reload(longint'($signed(cfg_data[31:0])));
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        filter_step(in_ch.meas_angle, in_ch.gyro_rate, in_ch.step_time);
      // result beat
      if (out_ch.valid && out_ch.ready) begin
        if (estimate_q.size() == 0) begin
          $display("unexpected result beat at %0t", $time);
          errors++;
        end else begin
          estimate_t e;
          e = estimate_q.pop_front();
          if (out_ch.angle_estimate !== e.angle)
            report("angle_estimate", out_ch.angle_estimate, e.angle);
          if (out_ch.bias_estimate !== e.bias)
            report("bias_estimate", out_ch.bias_estimate, e.bias);
        end
      end
    end
    pending = estimate_q.size();
  end

endmodule

[sim/angle_bias_kalman_filter_test.sv]
// Stimulus, clocking and verdict for the angle/bias Kalman filter.
module angle_bias_kalman_filter_test;
  import abkf_pkg::*;

  localparam logic [CIDX_W-1:0] REG_UNUSED = 3'd5;
  localparam logic [NV_W-1:0] NV_MAX = '1;
  localparam int DRAIN_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [NV_W-1:0] cfg_data = '0;
  logic calm = 0;
  int errors, pending, quiet;

  abkf_in_if in_ch();
  abkf_out_if out_ch();

  angle_bias_kalman_filter uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  abkf_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always #1 clk = ~clk;

  // drain and pause until the filter is idle
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [NV_W-1:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic write_all(logic [NV_W-1:0] qa, logic [NV_W-1:0] qb,
                           logic [NV_W-1:0] r, logic [31:0] a0);
    settle();
    write_reg(REG_ANGLE_NOISE, qa);
    write_reg(REG_BIAS_NOISE, qb);
    write_reg(REG_MEAS_NOISE, r);
    write_reg(REG_START_ANGLE, {16'd0, a0});
  endtask

  task automatic send(logic [31:0] meas, logic [31:0] rate, logic [31:0] dt);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.meas_angle = meas;
    in_ch.gyro_rate = rate;
    in_ch.step_time = dt;
    in_ch.valid = 1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  // mostly plausible IMU samples, some full-range noise
  task automatic send_random();
    if ($urandom_range(0, 9) < 7)
      send($urandom_range(0, 2 ** 21) - 2 ** 20, $urandom_range(0, 2 ** 21) - 2 ** 20,
           $urandom_range(2 ** 20, 2 ** 27));
    else
      send($urandom, $urandom, $urandom);
  endtask

  // result side stalls
  initial begin
    int stall;
    out_ch.ready = 0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ch.ready = 0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // watchdog on beats
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 0;
    in_ch.meas_angle = '0;
    in_ch.gyro_rate = '0;
    in_ch.step_time = '0;
    quiet = 0;
    repeat (8) @(negedge clk);
    rst = 0;

    // field extremes at reset settings
    send(32'h7fffffff, 32'h7fffffff, 32'hffffffff);
    send(32'h80000000, 32'h80000000, 32'hffffffff);
    send(32'h80000000, 32'h7fffffff, 32'd1);
    send(32'h7fffffff, 32'h80000000, 32'd1);
    send(32'h00010000, 32'h00000000, 32'd0);
    send(32'h00000000, 32'h00008000, 32'h00418937);
    send(32'hffff0000, 32'hfffe0000, 32'h80000000);

    // zero innovation variance: no noise, covariance cleared
    write_all('0, '0, '0, 32'h00050000);
    send(32'h7fffffff, 32'h00010000, 32'h10000000);
    send(32'h80000000, 32'h80000000, 32'hffffffff);
    // zero time step keeps prediction; with no noise the gain stays zero
    send(32'h00020000, 32'h00030000, 32'd0);

    // largest noise, extreme start angle, ignored register index
    write_all(NV_MAX, NV_MAX, NV_MAX, 32'h7fffffff);
    write_reg(REG_UNUSED, NV_MAX);
    repeat (6) send($urandom, $urandom, 32'hffffffff);
    write_all(NV_MAX, NV_MAX, 48'd1, 32'h80000000);
    repeat (6) send($urandom, $urandom, $urandom);

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST, 32'd0);
        1: write_all('0, '0, 48'd1, $urandom);
        2: write_all(NV_MAX, NV_MAX, NV_MAX, $urandom);
        3: write_all(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}), $urandom);
        4: write_all(48'({$urandom_range(0, 255), $urandom}),
                     48'({$urandom_range(0, 255), $urandom}),
                     48'({$urandom_range(0, 255), $urandom}), $urandom_range(0, 2 ** 20));
        default: write_all(ANGLE_NOISE_RST, BIAS_NOISE_RST, NV_MAX, 32'hffff0000);
      endcase
      calm = (ph == 2);
      repeat (250) send_random();
      calm = 0;
    end

    in_ch.valid = 0;
    settle();
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
